>>> design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types, status codes and the character classifier of the base64 decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // default depth of the job queue between front and back
  localparam int JOB_QUEUE_DEPTH = 4;

  // one input request
  typedef struct packed {
    logic [7:0] ch;
    logic       msg_last;
  } symbol_t;

  // one result request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       run_end;
    logic       msg_end;
    logic [1:0] status;
  } result_t;

  // a group of results caused by one character, bytes packed from slot 0
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            msg_end;
    logic [1:0]      status;
  } job_t;

  // classification of one character
  typedef struct packed {
    logic       valid;
    logic       pad;
    logic [5:0] sextet;
  } class_t;

  function automatic class_t classify(input logic [7:0] c);
    class_t r;
    r.valid  = 1'b1;
    r.pad    = 1'b0;
    r.sextet = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.sextet = 6'd62;
    end else if (c == 8'h2F) begin
      r.sextet = 6'd63;
    end else if (c == PAD_CHAR) begin
      r.pad = 1'b1;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> design/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// takes characters, tracks the quartet and turns each into a job or nothing
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  b64d_pkg::symbol_t  symbol,
  output logic               job_push,
  output b64d_pkg::job_t     job
);
  import b64d_pkg::*;

  logic [1:0]  quartet_pos, quartet_pos_next;
  logic [17:0] held_sextets, held_sextets_next;
  logic        third_was_pad, third_was_pad_next;
  logic        drop_until_end, drop_until_end_next;

  class_t     cls;
  logic [5:0] s0, s1, s2;
  logic [7:0] b0, b1, b2;

  always_comb begin
    cls = classify(symbol.ch);
    s0  = held_sextets[17:12];
    s1  = held_sextets[11:6];
    s2  = held_sextets[5:0];
    b0  = {s0, s1[5:4]};
    b1  = {s1[3:0], s2[5:2]};
    b2  = {s2[1:0], cls.sextet};
  end

  always_comb begin
    quartet_pos_next    = quartet_pos;
    held_sextets_next   = held_sextets;
    third_was_pad_next  = third_was_pad;
    drop_until_end_next = drop_until_end;
    job_push            = 1'b0;
    job.bytes           = '0;
    job.cnt             = 2'd1;
    job.msg_end         = 1'b1;
    job.status          = ST_OK;
    if (accept) begin
      if (drop_until_end) begin
        if (symbol.msg_last) begin
          drop_until_end_next = 1'b0;
          quartet_pos_next    = 2'd0;
          held_sextets_next   = '0;
          third_was_pad_next  = 1'b0;
        end
      end else if (!cls.valid) begin
        quartet_pos_next    = 2'd0;
        held_sextets_next   = '0;
        third_was_pad_next  = 1'b0;
        drop_until_end_next = !symbol.msg_last;
        job_push            = 1'b1;
        job.status          = ST_BAD_CHAR;
      end else if (quartet_pos != 2'd3) begin
        unique case (quartet_pos)
          2'd0:    held_sextets_next = {cls.sextet, 12'd0};
          2'd1:    held_sextets_next = {s0, cls.sextet, 6'd0};
          default: begin
            held_sextets_next  = {s0, s1, cls.sextet};
            third_was_pad_next = cls.pad;
          end
        endcase
        quartet_pos_next = quartet_pos + 2'd1;
        if (symbol.msg_last) begin
          quartet_pos_next   = 2'd0;
          held_sextets_next  = '0;
          third_was_pad_next = 1'b0;
          job_push           = 1'b1;
          job.status         = ST_BAD_LEN;
        end
      end else begin
        // fourth character: up to three bytes, pads knock out bytes two and three
        job_push     = 1'b1;
        job.bytes[0] = b0;
        job.bytes[1] = third_was_pad ? b2 : b1;
        job.bytes[2] = b2;
        job.cnt      = 2'd1 + {1'b0, !third_was_pad} + {1'b0, !cls.pad};
        job.msg_end  = symbol.msg_last;
        quartet_pos_next   = 2'd0;
        held_sextets_next  = '0;
        third_was_pad_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quartet_pos    <= 2'd0;
      held_sextets   <= '0;
      third_was_pad  <= 1'b0;
      drop_until_end <= 1'b0;
    end else begin
      quartet_pos    <= quartet_pos_next;
      held_sextets   <= held_sextets_next;
      third_was_pad  <= third_was_pad_next;
      drop_until_end <= drop_until_end_next;
    end
  end

endmodule

>>> design/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// small register queue of jobs between front and back
// ----------------------------------------------------------------------------
module b64d_queue #(
  parameter int Depth = b64d_pkg::JOB_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64d_pkg::job_t  wdata,
  output logic            full,
  input  logic            pop,
  output b64d_pkg::job_t  rdata,
  output logic            empty
);
  import b64d_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// plays out the results of each job, one per cycle while pop is high
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  b64d_pkg::job_t     q_job,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output b64d_pkg::result_t  result
);
  import b64d_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       at_last, take;

  assign at_last = (idx == cur.cnt - 2'd1);
  assign take    = !cur_valid || (pop && at_last);
  assign q_pop   = take && !q_empty;
  assign empty   = !cur_valid;

  always_comb begin
    unique case (idx)
      2'd0:    result.data_byte = cur.bytes[0];
      2'd1:    result.data_byte = cur.bytes[1];
      default: result.data_byte = cur.bytes[2];
    endcase
    result.run_end = at_last;
    result.msg_end = at_last && cur.msg_end;
    result.status  = cur.status;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (take) begin
      cur_valid <= !q_empty;
      idx       <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

>>> design/base64_decoder.sv
// ----------------------------------------------------------------------------
// base64_decoder
// streaming base64 decoder: one character in, up to three bytes out per quartet
// ----------------------------------------------------------------------------
//
//  channel  | handshake        | payload            | meaning
//  ---------+------------------+--------------------+-----------------------------
//  in       | push / full      | symbol (symbol_t)  | one character, last-of-message
//  out      | pop / empty      | result (result_t)  | byte or error, run/msg end
//
//  one character is taken per cycle while full is low; its job is written into the queue,
//  moves to the output register once the back end is free and can then be popped
//  the back end plays out one result per cycle while pop is high; a full quartet gives
//  three bytes for four input characters, and the queue absorbs bursts
//  full rises only when the job queue is full, i.e. when pop is held off
//  rst is synchronous and clears the quartet state, the queue and the output
//
module base64_decoder #(
  parameter int QueueDepth = b64d_pkg::JOB_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  b64d_pkg::symbol_t  symbol,
  output logic               full,
  input  logic               pop,
  output b64d_pkg::result_t  result,
  output logic               empty
);
  import b64d_pkg::*;

  logic accept;
  logic job_push;
  job_t job_in, job_out;
  logic q_empty, q_pop;

  // a request is taken whenever there is room for one more job
  assign accept = push && !full;

  // front: classify the character and keep the quartet
  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .symbol   (symbol),
    .job_push (job_push),
    .job      (job_in)
  );

  // job queue decouples character intake from byte delivery
  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (full),
    .pop   (q_pop),
    .rdata (job_out),
    .empty (q_empty)
  );

  // back: hand out each job's results in order
  b64d_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_job   (job_out),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
